// File: rtl/hrp_pkg.sv
// ----------------------------------------------------------------------------
// hrp_pkg: shared types and constants of the http request head parser
// method and version tables, token kinds, error codes and word types
// ----------------------------------------------------------------------------
package hrp_pkg;

  localparam int METHOD_NAME_MAX = 7;
  localparam int POS_W = $clog2(METHOD_NAME_MAX + 1);
  localparam int NUM_METHODS = 8;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // method names, zero padded, in method code order
  localparam logic [7:0] METH_NAME [NUM_METHODS][8] = '{
    '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
    '{"C", "O", "N", "N", "E", "C", "T", 8'h00},
    '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
    '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] METH_LEN [NUM_METHODS] = '{
    3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd7, 3'd7, 3'd5
  };

  localparam logic [7:0] VERSION_TEXT [8] = '{"H", "T", "T", "P", "/", "1", ".", "1"};

  typedef enum logic [3:0] {
    TK_HELD        = 4'd0,
    TK_METHOD_DONE = 4'd1,
    TK_URI_BYTE    = 4'd2,
    TK_URI_END     = 4'd3,
    TK_VERSION_OK  = 4'd4,
    TK_KEY_BYTE    = 4'd5,
    TK_VALUE_BYTE  = 4'd6,
    TK_HEADER_END  = 4'd7,
    TK_HEAD_DONE   = 4'd8,
    TK_LEFTOVER    = 4'd9,
    TK_ERROR       = 4'd10
  } tok_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_BAD_METHOD   = 3'd1,
    ERR_BAD_HEADER   = 3'd2,
    ERR_BAD_VERSION  = 3'd3,
    ERR_BAD_LINE_END = 3'd4
  } err_code_t;

  typedef enum logic [11:0] {
    PH_METHOD   = 12'b0000_0000_0001,
    PH_URI      = 12'b0000_0000_0010,
    PH_VERSION  = 12'b0000_0000_0100,
    PH_REQ_CR   = 12'b0000_0000_1000,
    PH_REQ_LF   = 12'b0000_0001_0000,
    PH_KEY      = 12'b0000_0010_0000,
    PH_COLON    = 12'b0000_0100_0000,
    PH_VALUE    = 12'b0000_1000_0000,
    PH_VALUE_LF = 12'b0001_0000_0000,
    PH_END_LF   = 12'b0010_0000_0000,
    PH_DONE     = 12'b0100_0000_0000,
    PH_ERROR    = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       new_request;
    logic       end_of_chunk;
  } hrp_in_t;

  typedef struct packed {
    tok_kind_t  token_kind;
    logic [7:0] out_byte;
    logic [2:0] method_code;
    err_code_t  fault_code;
    logic       chunk_done;
  } hrp_out_t;

  // method matcher verdict for one byte
  typedef struct packed {
    logic                   hit;
    logic [2:0]             hit_code;
    logic [NUM_METHODS-1:0] keep;
  } match_res_t;

endpackage

// File: rtl/http_request_head_parser.sv
// ----------------------------------------------------------------------------
// http_request_head_parser: byte-wide http/1.1 request head tokenizer
// tags every request byte with one token word
//
// usage:
// - in_* channel takes one word per byte: rx_byte, new_request (clear parse
//   state before this byte) and end_of_chunk (echoed as chunk_done)
// - out_* channel gives exactly one token word per input word, in order
// - both channels are valid/ready; a word moves when valid and ready are high
// - the token for an accepted word passes the input register, then the
//   result register, before it is on out_data
// - throughput: one word per cycle while out_ready stays high; the per-byte
//   parse state update is combinational logic between the two registers
// - when out_ready is low the result register holds and the input register
//   still takes one more word; in_ready drops only when both are full
// - synchronous reset empties both registers and puts the parser in the
//   method phase with all methods possible and no error latched
// ----------------------------------------------------------------------------
module http_request_head_parser import hrp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  hrp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output hrp_out_t out_data
);

  // input register
  logic     s1_valid_r, s1_valid_nxt;
  hrp_in_t  s1_data_r;

  // result register
  logic     out_valid_r, out_valid_nxt;
  hrp_out_t out_data_r;

  logic     adv;
  logic     step_en;
  hrp_out_t res;

  // result register free or being drained this cycle
  assign adv      = !out_valid_r || out_ready;
  // input register empty or moving on
  assign in_ready = adv || !s1_valid_r;
  // parse state advances only when a word leaves the input register
  assign step_en  = s1_valid_r && adv;

  hrp_parse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .in_word (s1_data_r),
    .res     (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (step_en) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/hrp_method_match.sv
// ----------------------------------------------------------------------------
// hrp_method_match: method name matcher
// checks one byte against all remaining method candidates in parallel
// ----------------------------------------------------------------------------
module hrp_method_match import hrp_pkg::*; (
  input  logic [7:0]             rx_byte,
  input  logic [NUM_METHODS-1:0] cand,
  input  logic [POS_W-1:0]       pos,
  output match_res_t             res
);

  always_comb begin
    res = '0;
    for (int m = 0; m < NUM_METHODS; m++) begin
      if (cand[m]) begin
        if (int'(pos) < int'(METH_LEN[m])) begin
          if (rx_byte == METH_NAME[m][pos[2:0]]) begin
            res.keep[m] = 1'b1;
          end
        end else if ((int'(pos) == int'(METH_LEN[m])) && (rx_byte == CH_SP)) begin
          res.hit      = 1'b1;
          res.hit_code = 3'(m);
        end
      end
    end
  end

endmodule

// File: rtl/hrp_parse_core.sv
// ----------------------------------------------------------------------------
// hrp_parse_core: parse state and per-byte next-state logic
// holds the phase and match state and tags the current word
// ----------------------------------------------------------------------------
module hrp_parse_core import hrp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step_en,
  input  hrp_in_t  in_word,
  output hrp_out_t res
);

  phase_t                 phase_r, phase_nxt, cur_phase;
  logic [NUM_METHODS-1:0] cand_r, cand_nxt, cur_cand;
  logic [POS_W-1:0]       pos_r, pos_nxt, cur_pos;
  logic                   uri_started_r, uri_started_nxt, cur_uri_started;
  logic                   line_empty_r, line_empty_nxt, cur_line_empty;
  logic [2:0]             method_r, method_nxt, cur_method;
  err_code_t              err_r, err_nxt, cur_err;
  match_res_t             mres;
  tok_kind_t              kind;
  logic                   pass;
  logic [7:0]             b;

  assign b = in_word.rx_byte;

  // new request clears the state before this byte
  always_comb begin
    if (in_word.new_request) begin
      cur_phase       = PH_METHOD;
      cur_cand        = '1;
      cur_pos         = '0;
      cur_uri_started = 1'b0;
      cur_line_empty  = 1'b1;
      cur_method      = 3'd0;
      cur_err         = ERR_NONE;
    end else begin
      cur_phase       = phase_r;
      cur_cand        = cand_r;
      cur_pos         = pos_r;
      cur_uri_started = uri_started_r;
      cur_line_empty  = line_empty_r;
      cur_method      = method_r;
      cur_err         = err_r;
    end
  end

  hrp_method_match u_match (
    .rx_byte (b),
    .cand    (cur_cand),
    .pos     (cur_pos),
    .res     (mres)
  );

  always_comb begin
    phase_nxt       = cur_phase;
    cand_nxt        = cur_cand;
    pos_nxt         = cur_pos;
    uri_started_nxt = cur_uri_started;
    line_empty_nxt  = cur_line_empty;
    method_nxt      = cur_method;
    err_nxt         = cur_err;
    kind            = TK_HELD;
    pass            = 1'b0;
    case (cur_phase)
      PH_METHOD: begin
        if (mres.hit) begin
          method_nxt      = mres.hit_code;
          phase_nxt       = PH_URI;
          uri_started_nxt = 1'b0;
          pos_nxt         = '0;
          kind            = TK_METHOD_DONE;
        end else if ((mres.keep == '0) || (int'(cur_pos) >= METHOD_NAME_MAX)) begin
          err_nxt   = ERR_BAD_METHOD;
          phase_nxt = PH_ERROR;
          kind      = TK_ERROR;
        end else begin
          cand_nxt = mres.keep;
          pos_nxt  = cur_pos + POS_W'(1);
        end
      end
      PH_URI: begin
        if (b == CH_SP) begin
          if (cur_uri_started) begin
            kind      = TK_URI_END;
            phase_nxt = PH_VERSION;
            pos_nxt   = '0;
          end
        end else begin
          uri_started_nxt = 1'b1;
          kind            = TK_URI_BYTE;
          pass            = 1'b1;
        end
      end
      PH_VERSION: begin
        if (b != VERSION_TEXT[cur_pos[2:0]]) begin
          err_nxt   = ERR_BAD_VERSION;
          phase_nxt = PH_ERROR;
          kind      = TK_ERROR;
        end else if (cur_pos[2:0] == 3'd7) begin
          kind      = TK_VERSION_OK;
          phase_nxt = PH_REQ_CR;
          pos_nxt   = '0;
        end else begin
          pos_nxt = cur_pos + POS_W'(1);
        end
      end
      PH_REQ_CR: begin
        if (b == CH_CR) begin
          phase_nxt = PH_REQ_LF;
        end else begin
          err_nxt   = ERR_BAD_LINE_END;
          phase_nxt = PH_ERROR;
          kind      = TK_ERROR;
        end
      end
      PH_REQ_LF: begin
        if (b == CH_LF) begin
          phase_nxt      = PH_KEY;
          line_empty_nxt = 1'b1;
        end else begin
          err_nxt   = ERR_BAD_LINE_END;
          phase_nxt = PH_ERROR;
          kind      = TK_ERROR;
        end
      end
      PH_KEY: begin
        if (b == CH_CR) begin
          if (cur_line_empty) begin
            phase_nxt = PH_END_LF;
          end else begin
            err_nxt   = ERR_BAD_HEADER;
            phase_nxt = PH_ERROR;
            kind      = TK_ERROR;
          end
        end else if (b == CH_COLON) begin
          line_empty_nxt = 1'b0;
          phase_nxt      = PH_COLON;
        end else begin
          line_empty_nxt = 1'b0;
          kind           = TK_KEY_BYTE;
          pass           = 1'b1;
        end
      end
      PH_COLON: begin
        if (b == CH_SP) begin
          phase_nxt = PH_VALUE;
        end else begin
          err_nxt   = ERR_BAD_HEADER;
          phase_nxt = PH_ERROR;
          kind      = TK_ERROR;
        end
      end
      PH_VALUE: begin
        if (b == CH_CR) begin
          phase_nxt = PH_VALUE_LF;
        end else begin
          kind = TK_VALUE_BYTE;
          pass = 1'b1;
        end
      end
      PH_VALUE_LF: begin
        if (b == CH_LF) begin
          kind           = TK_HEADER_END;
          phase_nxt      = PH_KEY;
          line_empty_nxt = 1'b1;
        end else begin
          err_nxt   = ERR_BAD_LINE_END;
          phase_nxt = PH_ERROR;
          kind      = TK_ERROR;
        end
      end
      PH_END_LF: begin
        if (b == CH_LF) begin
          kind      = TK_HEAD_DONE;
          phase_nxt = PH_DONE;
        end else begin
          err_nxt   = ERR_BAD_LINE_END;
          phase_nxt = PH_ERROR;
          kind      = TK_ERROR;
        end
      end
      PH_DONE: begin
        kind = TK_LEFTOVER;
        pass = 1'b1;
      end
      default: begin
        kind = TK_HELD;
      end
    endcase
  end

  always_comb begin
    res.token_kind  = kind;
    res.out_byte    = pass ? b : 8'h00;
    res.method_code = method_nxt;
    res.fault_code  = err_nxt;
    res.chunk_done  = in_word.end_of_chunk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_METHOD;
      cand_r        <= '1;
      pos_r         <= '0;
      uri_started_r <= 1'b0;
      line_empty_r  <= 1'b1;
      method_r      <= 3'd0;
      err_r         <= ERR_NONE;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      cand_r        <= cand_nxt;
      pos_r         <= pos_nxt;
      uri_started_r <= uri_started_nxt;
      line_empty_r  <= line_empty_nxt;
      method_r      <= method_nxt;
      err_r         <= err_nxt;
    end
  end

endmodule

// File: tb/sv/hrp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hrp_checker: token word predictor and scoreboard for the head parser
// watches both channels, predicts one token word per accepted byte word and
// compares every accepted token word, field by field, with the oldest one due
// ----------------------------------------------------------------------------
module hrp_checker import hrp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  hrp_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  hrp_out_t out_data,
  output int       fail_count,
  output int       pending
);

  // predictor copy of the parse state
  phase_t           phase;
  logic [7:0]       cand_set;
  logic [3:0]       match_pos;
  logic             uri_seen;
  logic             line_blank;
  logic [2:0]       meth_sel;
  err_code_t        err_latched;

  hrp_out_t         due_tokens [$];
  hrp_out_t         want_tok;

  function automatic void clear_parse();
    phase       = PH_METHOD;
    cand_set    = '1;
    match_pos   = '0;
    uri_seen    = 1'b0;
    line_blank  = 1'b1;
    meth_sel    = '0;
    err_latched = ERR_NONE;
  endfunction

  function automatic tok_kind_t raise_error(input err_code_t code);
    err_latched = code;
    phase       = PH_ERROR;
    return TK_ERROR;
  endfunction

  function automatic tok_kind_t match_method(input logic [7:0] b);
    logic [7:0] keep;
    int         hit;
    keep = '0;
    hit  = -1;
    for (int m = 0; m < NUM_METHODS; m++) begin
      if (cand_set[m]) begin
        if (match_pos < METH_LEN[m] && match_pos < 8 && b == METH_NAME[m][match_pos[2:0]])
          keep[m] = 1'b1;
        else if (match_pos == METH_LEN[m] && b == CH_SP)
          hit = m;
      end
    end
    if (hit >= 0) begin
      meth_sel  = hit[2:0];
      phase     = PH_URI;
      uri_seen  = 1'b0;
      match_pos = '0;
      return TK_METHOD_DONE;
    end
    if (keep == '0 || match_pos >= METHOD_NAME_MAX)
      return raise_error(ERR_BAD_METHOD);
    cand_set  = keep;
    match_pos = match_pos + 4'd1;
    return TK_HELD;
  endfunction

  function automatic hrp_out_t tokenize_byte(input hrp_in_t w);
    hrp_out_t   tok;
    tok_kind_t  kind;
    logic       carry;
    logic [7:0] b;
    b     = w.rx_byte;
    kind  = TK_HELD;
    carry = 1'b0;
    if (w.new_request) clear_parse();
    case (phase)
      PH_METHOD: kind = match_method(b);
      PH_URI: begin
        if (b == CH_SP) begin
          if (uri_seen) begin
            kind      = TK_URI_END;
            phase     = PH_VERSION;
            match_pos = '0;
          end
        end else begin
          uri_seen = 1'b1;
          kind     = TK_URI_BYTE;
          carry    = 1'b1;
        end
      end
      PH_VERSION: begin
        if (b != VERSION_TEXT[match_pos[2:0]]) begin
          kind = raise_error(ERR_BAD_VERSION);
        end else if (match_pos[2:0] == 3'd7) begin
          kind      = TK_VERSION_OK;
          phase     = PH_REQ_CR;
          match_pos = '0;
        end else begin
          match_pos = match_pos + 4'd1;
        end
      end
      PH_REQ_CR: begin
        if (b == CH_CR) phase = PH_REQ_LF;
        else kind = raise_error(ERR_BAD_LINE_END);
      end
      PH_REQ_LF: begin
        if (b == CH_LF) begin
          phase      = PH_KEY;
          line_blank = 1'b1;
        end else begin
          kind = raise_error(ERR_BAD_LINE_END);
        end
      end
      PH_KEY: begin
        if (b == CH_CR) begin
          if (line_blank) phase = PH_END_LF;
          else kind = raise_error(ERR_BAD_HEADER);
        end else if (b == CH_COLON) begin
          line_blank = 1'b0;
          phase      = PH_COLON;
        end else begin
          line_blank = 1'b0;
          kind       = TK_KEY_BYTE;
          carry      = 1'b1;
        end
      end
      PH_COLON: begin
        if (b == CH_SP) phase = PH_VALUE;
        else kind = raise_error(ERR_BAD_HEADER);
      end
      PH_VALUE: begin
        if (b == CH_CR) begin
          phase = PH_VALUE_LF;
        end else begin
          kind  = TK_VALUE_BYTE;
          carry = 1'b1;
        end
      end
      PH_VALUE_LF: begin
        if (b == CH_LF) begin
          kind       = TK_HEADER_END;
          phase      = PH_KEY;
          line_blank = 1'b1;
        end else begin
          kind = raise_error(ERR_BAD_LINE_END);
        end
      end
      PH_END_LF: begin
        if (b == CH_LF) begin
          kind  = TK_HEAD_DONE;
          phase = PH_DONE;
        end else begin
          kind = raise_error(ERR_BAD_LINE_END);
        end
      end
      PH_DONE: begin
        kind  = TK_LEFTOVER;
        carry = 1'b1;
      end
      default: kind = TK_HELD;
    endcase
    tok.token_kind  = kind;
    tok.out_byte    = carry ? b : 8'h00;
    tok.method_code = meth_sel;
    tok.fault_code  = err_latched;
    tok.chunk_done  = w.end_of_chunk;
    return tok;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      $display("t=%0t %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    clear_parse();
  end

  // token words leave before new byte words are predicted, so a token word
  // can never be matched against a byte word accepted at the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      due_tokens.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_tokens.size() == 0) begin
          fail_count++;
          $display("t=%0t unexpected token word: expected none, actual %p", $time, out_data);
        end else begin
          want_tok = due_tokens.pop_front();
          check_field("token_kind", 8'(want_tok.token_kind), 8'(out_data.token_kind));
          check_field("out_byte", want_tok.out_byte, out_data.out_byte);
          check_field("method_code", 8'(want_tok.method_code), 8'(out_data.method_code));
          check_field("fault_code", 8'(want_tok.fault_code), 8'(out_data.fault_code));
          check_field("chunk_done", 8'(want_tok.chunk_done), 8'(out_data.chunk_done));
        end
      end
      if (in_valid && in_ready) due_tokens.push_back(tokenize_byte(in_data));
    end
    pending = due_tokens.size();
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: request head parser regression
// feeds byte words of well-formed, damaged and noise request heads through
// the parser under three idling patterns; the checker predicts and compares
// every token word, this top makes stimulus and calls the verdict
// ----------------------------------------------------------------------------
module testbench;
  import hrp_pkg::*;

  localparam int PHASE_WORDS = 520;  // random byte words per idling pattern
  localparam int LONG_HOLD   = 400;  // receiver stall that fills the parser
  localparam int STALL_LIMIT = 3000; // cycles with no word moving at all

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  hrp_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  hrp_out_t out_data;

  int       fail_count;
  int       pending;

  // idling percentages, changed between patterns
  int       send_idle_pct;
  int       recv_idle_pct;
  // one-shot request for the receiver's long stall
  logic     hold_req;
  int       stall_cycles;

  // byte words waiting to be offered
  hrp_in_t  word_q [$];

  http_request_head_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  hrp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- stimulus
  // every byte word gets a random end_of_chunk so chunk_done is exercised
  task automatic queue_byte(input logic [7:0] b, input logic fresh);
    hrp_in_t w;
    w.rx_byte      = b;
    w.new_request  = fresh;
    w.end_of_chunk = ($urandom_range(7) == 0);
    word_q.push_back(w);
  endtask

  // text bytes; only the first one may start a new request
  task automatic queue_text(input string s, input logic fresh);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], fresh && i == 0);
  endtask

  // mostly printable bytes, some arbitrary, never one of the two barred ones
  function automatic logic [7:0] text_byte(input logic [7:0] bar_a, input logic [7:0] bar_b);
    logic [7:0] b;
    do begin
      if ($urandom_range(4) == 0) b = 8'($urandom_range(255));
      else b = 8'($urandom_range(8'h7e, 8'h20));
    end while (b == bar_a || b == bar_b);
    return b;
  endfunction

  // well-formed request head with random content, a quarter of them with one
  // byte overwritten so that the error paths get hit at random depths
  task automatic queue_request();
    logic [7:0] head_q [$];
    int         m;
    m = $urandom_range(NUM_METHODS - 1);
    for (int i = 0; i < METH_LEN[m]; i++) head_q.push_back(METH_NAME[m][i]);
    head_q.push_back(CH_SP);
    repeat ($urandom_range(2)) head_q.push_back(CH_SP);
    repeat ($urandom_range(12, 1)) head_q.push_back(text_byte(CH_SP, CH_SP));
    head_q.push_back(CH_SP);
    for (int i = 0; i < 8; i++) head_q.push_back(VERSION_TEXT[i]);
    head_q.push_back(CH_CR);
    head_q.push_back(CH_LF);
    repeat ($urandom_range(4)) begin
      repeat ($urandom_range(8)) head_q.push_back(text_byte(CH_CR, CH_COLON));
      head_q.push_back(CH_COLON);
      head_q.push_back(CH_SP);
      repeat ($urandom_range(10)) head_q.push_back(text_byte(CH_CR, CH_CR));
      head_q.push_back(CH_CR);
      head_q.push_back(CH_LF);
    end
    head_q.push_back(CH_CR);
    head_q.push_back(CH_LF);
    // body bytes past the head come out as leftover
    repeat ($urandom_range(6)) head_q.push_back(8'($urandom_range(255)));
    if ($urandom_range(3) == 0)
      head_q[$urandom_range(head_q.size() - 1)] = 8'($urandom_range(255));
    // mostly a clean start, now and then a restart in mid stream
    foreach (head_q[i])
      queue_byte(head_q[i], (i == 0 && $urandom_range(19) != 0) || $urandom_range(199) == 0);
  endtask

  task automatic queue_noise();
    repeat ($urandom_range(20, 1)) queue_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
  endtask

  // short directed part; \015 is cr and \012 is lf
  task automatic queue_directed();
    // complete head with one header, then leftover at both byte extremes
    queue_text("GET /a HTTP/1.1\015\012Host: x\015\012\015\012", 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hff, 1'b0);
    // every method name but GET followed by a space
    for (int m = 1; m < NUM_METHODS; m++) begin
      for (int i = 0; i < METH_LEN[m]; i++) queue_byte(METH_NAME[m][i], i == 0);
      queue_byte(CH_SP, 1'b0);
    end
    // method mismatch, early space, name too long
    queue_text("GEX", 1'b1);
    queue_text("GE ", 1'b1);
    queue_text("OPTIONSX", 1'b1);
    // spaces before uri, then a version mismatch; held bytes after the error
    queue_text("PUT   /p  HTTP/1.0", 1'b1);
    queue_text("junk", 1'b0);
    // request line not closed by cr lf
    queue_text("POST /p HTTP/1.1X", 1'b1);
    queue_text("POST /p HTTP/1.1\015X", 1'b1);
    // colon without space, cr inside a key
    queue_text("GET / HTTP/1.1\015\012K:v", 1'b1);
    queue_text("GET / HTTP/1.1\015\012Key\015", 1'b1);
    // empty key accepted, then lone cr on the empty line
    queue_text("GET / HTTP/1.1\015\012: v\015\012\015X", 1'b1);
    // lone cr in a value
    queue_text("GET / HTTP/1.1\015\012K: a\015b", 1'b1);
    // lf inside key and value is plain data
    queue_text("GET / HTTP/1.1\015\012K\012: v\012\015\012\015\012zz", 1'b1);
    // restart in the middle of a method name
    queue_text("TRA", 1'b1);
    queue_text("TRACE /t HTTP/1.1\015\012\015\012", 1'b1);
  endtask

  // ------------------------------------------------------------------ driving
  // valid goes up at a falling edge and stays up, payload unchanged, until
  // the word is taken at a rising edge
  task automatic send_word(input hrp_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_queued(inout int sent);
    while (word_q.size() > 0) begin
      send_word(word_q.pop_front());
      sent++;
    end
  endtask

  // sender goes quiet until every predicted token word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // receiver: random ready, or one long stall when asked for
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  <= 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: nothing moving on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------ main
  initial begin
    int   sent;
    logic held;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    hold_req      = 1'b0;
    stall_cycles  = 0;
    send_idle_pct = 27;
    recv_idle_pct = 51;
    held          = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int mode = 0; mode < 3; mode++) begin
      // sender 27 / receiver 51, then swapped, then no idling at all
      send_idle_pct <= (mode == 0) ? 27 : (mode == 1) ? 51 : 0;
      recv_idle_pct <= (mode == 0) ? 51 : (mode == 1) ? 27 : 0;
      sent = 0;
      if (mode == 0) begin
        queue_directed();
        send_queued(sent);
        wait_drained();
        sent = 0;
      end
      while (sent < PHASE_WORDS) begin
        if ($urandom_range(99) < 85) queue_request();
        else queue_noise();
        send_queued(sent);
        // long receiver stall while words keep coming, so the input backs up
        if (mode == 0 && !held && sent >= 200) begin
          hold_req <= 1'b1;
          held = 1'b1;
        end
      end
      wait_drained();
    end

    // idle cycles before the verdict catch stray token words
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: http_request_head_parser.f
rtl/hrp_pkg.sv
rtl/hrp_method_match.sv
rtl/hrp_parse_core.sv
rtl/http_request_head_parser.sv
tb/sv/hrp_checker.sv
tb/sv/testbench.sv
